/* hdl/fcca_pkg.sv */
// ----------------------------------------------------------------------------
// fcca_pkg
// shared constants and codes for the fat16 cluster chain allocator
// ----------------------------------------------------------------------------
package fcca_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 13;
    localparam int WORD_W      = 16;

    localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_ENTRIES);

    localparam logic [WORD_W-1:0] EOC_MIN   = 16'hFFF8;
    localparam logic [WORD_W-1:0] EOC_MARK  = 16'hFFFF;
    localparam logic [WORD_W-1:0] FREE_MARK = 16'h0000;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;
    localparam logic [1:0] CMD_FREE  = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_LONG  = 2'd3;

endpackage

/* hdl/fat_cluster_chain_allocator_unit.sv */
// load and out-of-range items answer straight from idle, read waits on the
// registered table read, allocate scans from index 2 for the first free entry
// (then writes the link when linking), free reads then clears each link
// one item at a time: the next item is taken the cycle after its result leaves
// after reset a clearing pass zeroes every table entry before the first item
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_unit
// fat16 allocation table with load, read, allocate-and-link and free-chain
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_unit
    import fcca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              entry_count_we,
    input  logic [CNT_W-1:0]  entry_count_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // cluster[15:0], value[31:16]
    input  logic [1:0]        s_axis_tuser,   // command[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata    // result_cluster[15:0],
                                              // freed_count[28:16], status[30:29]
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_LINK   = 3'd4;
    localparam logic [2:0] S_FCHK   = 3'd5;
    localparam logic [2:0] S_FRD    = 3'd6;

    logic [WORD_W-1:0] mem [MAX_ENTRIES];
    logic [WORD_W-1:0] rd_data_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  entry_count_reg;
    logic [CNT_W-1:0]  n_used;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [WORD_W-1:0] cl_reg, cl_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  chk_reg, chk_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]  freed_reg, freed_next;

    logic              out_vld_reg, out_vld_next;
    logic [WORD_W-1:0] out_res_reg, out_res_next;
    logic [CNT_W-1:0]  out_freed_reg, out_freed_next;
    logic [1:0]        out_stat_reg, out_stat_next;

    logic              accept;
    logic [1:0]        in_cmd;
    logic [WORD_W-1:0] in_cl;
    logic [WORD_W-1:0] in_val;
    logic              in_range;
    logic              cur_in_chain;

    assign n_used = (entry_count_reg > MAX_COUNT) ? MAX_COUNT : entry_count_reg;

    assign in_cmd = s_axis_tuser;
    assign in_cl  = s_axis_tdata[15:0];
    assign in_val = s_axis_tdata[31:16];

    assign s_axis_tready = (state_reg == S_IDLE) && !out_vld_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_range      = in_cl < {3'b000, n_used};
    assign cur_in_chain  = (cur_reg >= 16'd2) && (cur_reg < EOC_MIN);

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_stat_reg, out_freed_reg, out_res_reg};

    // table storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            entry_count_reg <= MAX_COUNT;
            clr_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
            if (entry_count_we)
            begin
                entry_count_reg <= entry_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cl_reg        <= cl_next;
        cur_reg       <= cur_next;
        scan_reg      <= scan_next;
        chk_reg       <= chk_next;
        freed_reg     <= freed_next;
        out_res_reg   <= out_res_next;
        out_freed_reg <= out_freed_next;
        out_stat_reg  <= out_stat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cl_next        = cl_reg;
        cur_next       = cur_reg;
        scan_next      = scan_reg;
        chk_next       = chk_reg;
        chk_vld_next   = chk_vld_reg;
        freed_next     = freed_reg;
        out_vld_next   = out_vld_reg && !m_axis_tready;
        out_res_next   = out_res_reg;
        out_freed_next = out_freed_reg;
        out_stat_next  = out_stat_reg;
        mem_we         = 1'b0;
        mem_waddr      = in_cl[IDX_W-1:0];
        mem_wdata      = in_val;
        mem_raddr      = in_cl[IDX_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = FREE_MARK;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cl_next        = in_cl;
                    cur_next       = in_cl;
                    freed_next     = '0;
                    scan_next      = CNT_W'(2);
                    chk_vld_next   = 1'b0;
                    out_res_next   = '0;
                    out_freed_next = '0;
                    out_stat_next  = STAT_OK;
                    case (in_cmd)
                        CMD_LOAD:
                        begin
                            out_vld_next = 1'b1;
                            if (in_range)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                out_stat_next = STAT_RANGE;
                            end
                        end
                        CMD_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                out_vld_next  = 1'b1;
                                out_stat_next = STAT_RANGE;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (in_cl != '0 && !in_range)
                            begin
                                out_vld_next  = 1'b1;
                                out_stat_next = STAT_RANGE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FCHK;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                out_vld_next = 1'b1;
                out_res_next = rd_data_reg;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                // reads run one entry ahead of the compare
                mem_raddr = scan_reg[IDX_W-1:0];
                if (chk_vld_reg && rd_data_reg == FREE_MARK)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = chk_reg[IDX_W-1:0];
                    mem_wdata    = EOC_MARK;
                    out_res_next = {3'b000, chk_reg};
                    chk_vld_next = 1'b0;
                    if (cl_reg != '0)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        out_vld_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (scan_reg < n_used)
                begin
                    chk_next     = scan_reg;
                    chk_vld_next = 1'b1;
                    scan_next    = scan_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next  = 1'b0;
                    out_vld_next  = 1'b1;
                    out_stat_next = STAT_FULL;
                    state_next    = S_IDLE;
                end
            end
            S_LINK:
            begin
                mem_we       = 1'b1;
                mem_waddr    = cl_reg[IDX_W-1:0];
                mem_wdata    = {3'b000, chk_reg};
                out_vld_next = 1'b1;
                state_next   = S_IDLE;
            end
            S_FCHK:
            begin
                mem_raddr = cur_reg[IDX_W-1:0];
                if (!cur_in_chain)
                begin
                    out_vld_next   = 1'b1;
                    out_freed_next = freed_reg;
                    state_next     = S_IDLE;
                end
                else if (cur_reg >= {3'b000, n_used})
                begin
                    out_vld_next   = 1'b1;
                    out_freed_next = freed_reg;
                    out_stat_next  = STAT_RANGE;
                    state_next     = S_IDLE;
                end
                else if (freed_reg >= n_used)
                begin
                    out_vld_next   = 1'b1;
                    out_freed_next = freed_reg;
                    out_stat_next  = STAT_LONG;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                // clear the link just read and follow it
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[IDX_W-1:0];
                mem_wdata  = FREE_MARK;
                freed_next = freed_reg + 1'b1;
                cur_next   = rd_data_reg;
                state_next = S_FCHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fat16 cluster chain allocator: a directed
// table of commands and then random chain traffic over several table sizes,
// each result compared against a typed expectation or a mirror of the table
// ----------------------------------------------------------------------------
module tb
    import fcca_pkg::*;
();

    localparam int IDLE_LIMIT   = 40000;
    localparam int PHASE_ITEMS  = 130;
    localparam int HEADS_MAX    = 24;

    typedef struct packed {
        logic [WORD_W-1:0] cluster;
        logic [CNT_W-1:0]  freed;
        logic [1:0]        status;
    } chain_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        cmd;
        logic [WORD_W-1:0] cl;
        logic [WORD_W-1:0] val;
        logic              typed;
        chain_result_t     want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              entry_count_we;
    logic [CNT_W-1:0]  entry_count_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;   // cluster[15:0], value[31:16]
    logic [1:0]        s_axis_tuser;   // command[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;   // result_cluster[15:0], freed_count[28:16],
                                       // status[30:29]

    logic [WORD_W-1:0] fat_mirror [0:MAX_ENTRIES-1];
    logic [CNT_W-1:0]  cfg_entries;
    chain_result_t     pending_results[$];
    dir_row_t          dir_rows[$];
    int                error_count = 0;
    int                idle_cycles = 0;
    int                burst_left  = 0;
    int                rx_mode      = 0;
    int                rx_mode_left = 0;
    int                rx_stall     = 0;
    chain_result_t     got_result;
    chain_result_t     want_result;

    fat_cluster_chain_allocator_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .entry_count_we    (entry_count_we),
        .entry_count_wdata (entry_count_wdata),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int used_count();
        int n;
        n = int'(cfg_entries);
        if (n > MAX_ENTRIES)
            n = MAX_ENTRIES;
        return n;
    endfunction

    // updates the table mirror and returns what the block should answer
    function automatic chain_result_t fat_apply(input logic [1:0] cmd,
                                                input logic [WORD_W-1:0] cl,
                                                input logic [WORD_W-1:0] val);
        chain_result_t r;
        int n;
        int c;
        int cur;
        int nxt;
        bit done;
        n = used_count();
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_LOAD:
            begin
                if (int'(cl) < n)
                    fat_mirror[cl] = val;
                else
                    r.status = STAT_RANGE;
            end
            CMD_READ:
            begin
                if (int'(cl) < n)
                    r.cluster = fat_mirror[cl];
                else
                    r.status = STAT_RANGE;
            end
            CMD_ALLOC:
            begin
                if (cl != 0 && int'(cl) >= n)
                    r.status = STAT_RANGE;
                else
                begin
                    done = 1'b0;
                    c = 2;
                    while (!done && c < n)
                    begin
                        if (fat_mirror[c] == FREE_MARK)
                            done = 1'b1;
                        else
                            c++;
                    end
                    if (!done)
                        r.status = STAT_FULL;
                    else
                    begin
                        // end-of-chain mark first, so a self link wins
                        fat_mirror[c] = EOC_MARK;
                        if (cl != 0)
                            fat_mirror[cl] = WORD_W'(c);
                        r.cluster = WORD_W'(c);
                    end
                end
            end
            default:
            begin
                cur = int'(cl);
                done = 1'b0;
                while (!done && cur >= 2 && cur < int'(EOC_MIN))
                begin
                    if (cur >= n)
                    begin
                        r.status = STAT_RANGE;
                        done = 1'b1;
                    end
                    else if (int'(r.freed) >= n)
                    begin
                        r.status = STAT_LONG;
                        done = 1'b1;
                    end
                    else
                    begin
                        nxt = int'(fat_mirror[cur]);
                        fat_mirror[cur] = FREE_MARK;
                        r.freed = r.freed + 1'b1;
                        cur = nxt;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_index(input int n);
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return WORD_W'(n);
            1: return WORD_W'($urandom_range(n, 65535));
            2: return 16'hFFFF;
            3: return WORD_W'(n - 1);
            default: return WORD_W'($urandom_range(0, n - 1));
        endcase
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [1:0] cmd,
                           input logic [WORD_W-1:0] cl, input logic [WORD_W-1:0] val,
                           input logic typed, input logic [WORD_W-1:0] res,
                           input logic [CNT_W-1:0] freed, input logic [1:0] st);
        dir_row_t row;
        row.kind = kind;
        row.cmd = cmd;
        row.cl = cl;
        row.val = val;
        row.typed = typed;
        row.want.cluster = res;
        row.want.freed = freed;
        row.want.status = st;
        dir_rows.push_back(row);
    endtask

    // presents one item, waits for the handshake and queues its expectation
    task automatic send_item(input logic [1:0] cmd, input logic [WORD_W-1:0] cl,
                             input logic [WORD_W-1:0] val, input logic typed,
                             input chain_result_t typed_want, output chain_result_t r);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, cl};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = fat_apply(cmd, cl, val);
        pending_results.push_back(typed ? typed_want : r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [CNT_W-1:0] v);
        drain_results();
        repeat (8) @(posedge clk);
        entry_count_we    <= 1'b1;
        entry_count_wdata <= v;
        @(posedge clk);
        entry_count_we <= 1'b0;
        cfg_entries = v;
    endtask

    // receiver: free-running, random, or long stalls, switching at random
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(20, 300);
        end
        else
            rx_mode_left <= rx_mode_left - 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    rx_stall      <= rx_stall - 1;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 4) == 0)
                        rx_stall <= $urandom_range(1, 40);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result.cluster = m_axis_tdata[15:0];
            got_result.freed   = m_axis_tdata[28:16];
            got_result.status  = m_axis_tdata[30:29];
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result.cluster !== want_result.cluster)
                begin
                    $display("%0t: result_cluster exp %h got %h", $time,
                             want_result.cluster, got_result.cluster);
                    error_count++;
                end
                if (got_result.freed !== want_result.freed)
                begin
                    $display("%0t: freed_count exp %0d got %0d", $time,
                             want_result.freed, got_result.freed);
                    error_count++;
                end
                if (got_result.status !== want_result.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time,
                             want_result.status, got_result.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int             phase_counts[8];
        int             n;
        int             r;
        int             sel;
        logic [1:0]     cmd;
        logic [WORD_W-1:0] cl;
        logic [WORD_W-1:0] val;
        logic [WORD_W-1:0] last_alloc;
        logic [WORD_W-1:0] chain_heads[$];
        chain_result_t  res;
        dir_row_t       row;

        rst_n             = 1'b0;
        entry_count_we    = 1'b0;
        entry_count_wdata = '0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tuser      = CMD_LOAD;
        cfg_entries       = MAX_COUNT;
        for (int i = 0; i < MAX_ENTRIES; i++)
            fat_mirror[i] = FREE_MARK;

        // empty table, full size
        add_row(ROW_ITEM, CMD_READ,  16'd0,      16'd0,    1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_READ,  16'd4095,   16'd0,    1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_READ,  16'd4096,   16'd0,    1, 16'd0,    0, STAT_RANGE);
        add_row(ROW_ITEM, CMD_LOAD,  16'hFFFF,   16'hFFFF, 1, 16'd0,    0, STAT_RANGE);
        add_row(ROW_ITEM, CMD_LOAD,  16'd4095,   16'hFFFF, 1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_READ,  16'd4095,   16'd0,    1, 16'hFFFF, 0, STAT_OK);
        add_row(ROW_ITEM, CMD_ALLOC, 16'd0,      16'd0,    1, 16'd2,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_ALLOC, 16'd2,      16'd0,    1, 16'd3,    0, STAT_OK);
        // previous cluster one links like any other
        add_row(ROW_ITEM, CMD_ALLOC, 16'd1,      16'd0,    1, 16'd4,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_ALLOC, 16'hFFFF,   16'd0,    1, 16'd0,    0, STAT_RANGE);
        add_row(ROW_ITEM, CMD_READ,  16'd2,      16'd0,    1, 16'd3,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_FREE,  16'd2,      16'd0,    1, 16'd0,    2, STAT_OK);
        // starts outside any chain clear nothing
        add_row(ROW_ITEM, CMD_FREE,  16'd0,      16'd0,    1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_FREE,  16'd1,      16'd0,    1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_FREE,  EOC_MIN,    16'd0,    1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_FREE,  16'hFFFF,   16'd0,    1, 16'd0,    0, STAT_OK);
        // self loop: the cleared entry is counted once more
        add_row(ROW_ITEM, CMD_LOAD,  16'd5,      16'd5,    1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_FREE,  16'd5,      16'd0,    1, 16'd0,    2, STAT_OK);
        // walk leaves the table
        add_row(ROW_ITEM, CMD_LOAD,  16'd6,      16'd4096, 1, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_FREE,  16'd6,      16'd0,    1, 16'd0,    1, STAT_RANGE);
        // new cluster linked to itself
        add_row(ROW_ITEM, CMD_ALLOC, 16'd2,      16'd0,    1, 16'd2,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_READ,  16'd2,      16'd0,    0, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_LOAD,  16'h0AAA,   16'h5555, 0, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_LOAD,  16'h0555,   16'hAAAA, 0, 16'd0,    0, STAT_OK);
        // smallest table: full, range and a walk over its only chain entry
        add_row(ROW_CFG,  CMD_LOAD,  16'd0,      16'd3,    0, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_ALLOC, 16'd0,      16'd0,    1, 16'd0,    0, STAT_FULL);
        add_row(ROW_ITEM, CMD_READ,  16'd3,      16'd0,    1, 16'd0,    0, STAT_RANGE);
        add_row(ROW_ITEM, CMD_FREE,  16'd2,      16'd0,    0, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_ALLOC, 16'd0,      16'd0,    0, 16'd0,    0, STAT_OK);
        add_row(ROW_ITEM, CMD_ALLOC, 16'd2,      16'd0,    0, 16'd0,    0, STAT_OK);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                set_entry_count(CNT_W'(row.val));
            else
                send_item(row.cmd, row.cl, row.val, row.typed, row.want, res);
        end

        phase_counts = '{16, 3, 40, 4096, 100, 8191, 7, 255};
        foreach (phase_counts[p])
        begin
            set_entry_count(CNT_W'(phase_counts[p]));
            n = used_count();
            last_alloc = '0;
            chain_heads.delete();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                val = '0;
                if (r < 15)
                begin
                    cmd = CMD_LOAD;
                    cl = pick_index(n);
                    sel = $urandom_range(0, 5);
                    case (sel)
                        0, 1: val = WORD_W'($urandom_range(0, n - 1));
                        2: val = WORD_W'($urandom_range(EOC_MIN, 65535));
                        3: val = FREE_MARK;
                        4: val = WORD_W'($urandom_range(n, n + 5));
                        default: val = WORD_W'($urandom);
                    endcase
                end
                else if (r < 35)
                begin
                    cmd = CMD_READ;
                    cl = ($urandom_range(0, 2) == 0) ? last_alloc : pick_index(n);
                end
                else if (r < 70)
                begin
                    cmd = CMD_ALLOC;
                    sel = $urandom_range(0, 9);
                    if (sel < 6)
                        cl = last_alloc;
                    else if (sel < 8)
                        cl = '0;
                    else
                        cl = pick_index(n);
                end
                else
                begin
                    cmd = CMD_FREE;
                    if (chain_heads.size() != 0 && $urandom_range(0, 2) != 0)
                    begin
                        sel = $urandom_range(0, chain_heads.size() - 1);
                        cl = chain_heads[sel];
                        chain_heads.delete(sel);
                    end
                    else if ($urandom_range(0, 3) == 0)
                        cl = WORD_W'($urandom_range(EOC_MIN, 65535));
                    else
                        cl = pick_index(n);
                end
                send_item(cmd, cl, val, 1'b0, '0, res);
                if (cmd == CMD_ALLOC)
                begin
                    if (res.status == STAT_OK)
                    begin
                        last_alloc = res.cluster;
                        if (cl == 0)
                            chain_heads.push_back(res.cluster);
                        if (chain_heads.size() > HEADS_MAX)
                            void'(chain_heads.pop_front());
                    end
                    else if (res.status == STAT_FULL)
                        last_alloc = '0;
                end
                // let the block run dry once per phase
                if (k == PHASE_ITEMS / 2)
                    drain_results();
            end
        end

        drain_results();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
hdl/fcca_pkg.sv
hdl/fat_cluster_chain_allocator_unit.sv
dv/tb.sv
